>>> hw/rtl/adsr_pkg.sv
// Package for the ADSR envelope block: widths, register indexes, segment codes,
// root table and shared stage types. No dependencies.
package adsr_pkg;
   localparam int TIME_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int AMP_W          = 16;
   localparam int SEG_W          = 3;

   typedef enum logic [SEG_W-1:0] {
      SEG_ATTACK  = 3'd0,
      SEG_DECAY   = 3'd1,
      SEG_SUSTAIN = 3'd2,
      SEG_RELEASE = 3'd3,
      SEG_OUTSIDE = 3'd4
   } seg_type;

   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_LEN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_LEN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUSTAIN_LEN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_CURVE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_CURVE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_CURVE = 3'd7;

   // how the power is formed: from the log, forced to one, forced to zero
   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_ONE    = 2'd1;
   localparam logic [1:0] KIND_ZERO   = 2'd2;

   localparam logic [15:0] LEVEL_ONE = 16'd32768;
   localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

   // Side data that rides along the pipeline with each item.
   typedef struct packed {
      seg_type     seg;
      logic [15:0] lvl;
      logic [15:0] curve;
   } side_type;

   // isqrt of val (callers pass v<<30), 64-bit arithmetic, used only at elaboration.
   function automatic logic [63:0] isqrt_c(input logic [63:0] val);
      logic [63:0] v, res, bit_v;
      v = val; res = 0; bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-i) in Q2.30
   function automatic logic [31:0] root_c(input int idx);
      logic [63:0] v;
      v = 64'd1 << 29;
      for (int i = 1; i <= idx; i++) v = isqrt_c(v << 30);
      return v[31:0];
   endfunction
endpackage

>>> hw/rtl/adsr_seg_div.sv
// Segment select and pipelined restoring divider, one quotient bit per stage.
// Depends on adsr_pkg.
module adsr_seg_div #(
   parameter int TIME_WIDTH = adsr_pkg::TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = adsr_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [31:0]              in_time,
   input  logic [3:0][31:0]         seg_len,
   input  logic [15:0]              lvl,
   input  logic [2:0][15:0]         curves,
   output logic                     out_valid,
   output logic [FRAC_BITS:0]       out_base,
   output adsr_pkg::side_type       out_side
);
   localparam int SW = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 2;
   localparam int NS = FRAC_BITS + 1;
   localparam logic [SW-1:0] LEN_MASK = (SW'(1) << TIME_WIDTH) - SW'(1);

   logic [NS-1:0]                 v_ff;
   logic [NS-1:0][SW-1:0]         num_ff;
   logic [NS-1:0][SW-1:0]         den_ff;
   logic [NS-1:0][FRAC_BITS-1:0]  q_ff;
   adsr_pkg::side_type [NS-1:0]   side_ff;

   // stage 0: locate segment
   logic [SW-1:0] t_in, acc, len_k, rel_in, den_in;
   adsr_pkg::side_type side_in;
   logic found;
   always_comb begin
      t_in    = SW'(in_time);
      acc     = '0;
      found   = 1'b0;
      rel_in  = '0;
      den_in  = SW'(1);
      len_k   = '0;
      side_in.seg   = adsr_pkg::SEG_OUTSIDE;
      side_in.lvl   = lvl;
      side_in.curve = curves[0];
      for (int k = 0; k < 4; k++) begin
         len_k = SW'(seg_len[k]) & LEN_MASK;
         if (!found && !in_time[31] && (t_in < acc + len_k)) begin
            found = 1'b1;
            rel_in = t_in - acc;
            den_in = len_k;
            side_in.seg = adsr_pkg::seg_type'(3'(k));
            side_in.curve = curves[(k == 3) ? 2'd2 : ((k == 0) ? 2'd0 : 2'd1)];
         end
         acc = acc + len_k;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
      num_ff[0]  <= rel_in;
      den_ff[0]  <= den_in;
      q_ff[0]    <= '0;
      side_ff[0] <= side_in;
      for (int s = 1; s < NS; s++) begin
         logic [SW-1:0] sh;
         sh = num_ff[s-1] << 1;
         if (sh >= den_ff[s-1]) begin
            num_ff[s] <= sh - den_ff[s-1];
            q_ff[s]   <= {q_ff[s-1][FRAC_BITS-2:0], 1'b1};
         end else begin
            num_ff[s] <= sh;
            q_ff[s]   <= {q_ff[s-1][FRAC_BITS-2:0], 1'b0};
         end
         den_ff[s]  <= den_ff[s-1];
         side_ff[s] <= side_ff[s-1];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_side  = side_ff[NS-1];
   // attack uses x; decay, release and the other segments use 1-x
   assign out_base  = (side_ff[NS-1].seg == adsr_pkg::SEG_ATTACK) ?
                      {1'b0, q_ff[NS-1]} :
                      ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, q_ff[NS-1]};
endmodule

>>> hw/rtl/adsr_log.sv
// Pipelined -log2 by repeated squaring, one squaring per stage, then times
// the Q8.8 exponent. Depends on adsr_pkg.
module adsr_log #(
   parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [FRAC_BITS:0]       in_base,
   input  adsr_pkg::side_type       in_side,
   output logic                     out_valid,
   output logic [63:0]              out_p,
   output logic [1:0]               out_kind,
   output adsr_pkg::side_type       out_side
);
   localparam int NS = 33;
   localparam int MW = $clog2(FRAC_BITS + 1);

   logic [NS-1:0]               v_ff;
   logic [NS-1:0][31:0]         m_ff;
   logic [NS-1:0][31:0]         lf_ff;
   logic [NS-1:0][MW-1:0]       msb_ff;
   logic [NS-1:0][1:0]          kind_ff;
   adsr_pkg::side_type [NS-1:0] side_ff;

   logic [MW-1:0] msb_in;
   logic [1:0]    kind_in;
   always_comb begin
      msb_in = '0;
      for (int b = 0; b < FRAC_BITS; b++) if (in_base[b]) msb_in = MW'(b);
      if (in_side.curve == 16'd0 || in_base[FRAC_BITS]) kind_in = adsr_pkg::KIND_ONE;
      else if (in_base == '0) kind_in = adsr_pkg::KIND_ZERO;
      else kind_in = adsr_pkg::KIND_NORMAL;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[NS-2:0], in_valid};
      m_ff[0]    <= 32'(in_base[FRAC_BITS-1:0]) << (30 - 32'(msb_in));
      lf_ff[0]   <= '0;
      msb_ff[0]  <= msb_in;
      kind_ff[0] <= kind_in;
      side_ff[0] <= in_side;
      for (int s = 1; s < NS; s++) begin
         logic [63:0] sq;
         sq = (64'(m_ff[s-1]) * 64'(m_ff[s-1])) >> 30;
         if (sq >= 64'h8000_0000) begin
            m_ff[s]  <= sq[32:1];
            lf_ff[s] <= {lf_ff[s-1][30:0], 1'b1};
         end else begin
            m_ff[s]  <= sq[31:0];
            lf_ff[s] <= {lf_ff[s-1][30:0], 1'b0};
         end
         msb_ff[s]  <= msb_ff[s-1];
         kind_ff[s] <= kind_ff[s-1];
         side_ff[s] <= side_ff[s-1];
      end
   end

   // multiply stage: neg_log (at most 37 bits) times 16-bit exponent
   logic        vm_ff;
   logic [63:0] p_ff;
   logic [1:0]  km_ff;
   adsr_pkg::side_type sm_ff;
   logic [63:0] neg_log;
   logic [52:0] p_full;
   assign neg_log = (64'(FRAC_BITS - 32'(msb_ff[NS-1])) << 32) - 64'(lf_ff[NS-1]);
   assign p_full  = 53'(neg_log[36:0]) * 53'(side_ff[NS-1].curve);
   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else vm_ff <= v_ff[NS-1];
      p_ff  <= 64'(p_full >> 8);
      km_ff <= kind_ff[NS-1];
      sm_ff <= side_ff[NS-1];
   end
   assign out_valid = vm_ff;
   assign out_p     = p_ff;
   assign out_kind  = km_ff;
   assign out_side  = sm_ff;
endmodule

>>> hw/rtl/adsr_exp.sv
// Pipelined 2^-p from a product of roots, one root per stage, then scale
// and blend into the output amplitude. Depends on adsr_pkg.
module adsr_exp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [63:0]          in_p,
   input  logic [1:0]           in_kind,
   input  adsr_pkg::side_type   in_side,
   output logic                 out_valid,
   output logic [15:0]          out_amp,
   output logic [2:0]           out_seg
);
   localparam int NS = 31;

   logic [NS-1:0]               v_ff;
   logic [NS-1:0][31:0]         r_ff;
   logic [NS-1:0][31:0]         fp_ff;
   logic [NS-1:0][4:0]          ip_ff;
   logic [NS-1:0]               zero_ff;
   adsr_pkg::side_type [NS-1:0] side_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[NS-2:0], in_valid};
      r_ff[0]    <= adsr_pkg::ONE_Q30;
      fp_ff[0]   <= (in_kind == adsr_pkg::KIND_ONE) ? 32'd0 : in_p[31:0];
      ip_ff[0]   <= (in_kind == adsr_pkg::KIND_ONE) ? 5'd0 : in_p[36:32];
      zero_ff[0] <= (in_kind == adsr_pkg::KIND_ZERO) ||
                    ((in_kind == adsr_pkg::KIND_NORMAL) && (in_p[63:32] >= 32'd31));
      side_ff[0] <= in_side;
      for (int s = 1; s < NS; s++) begin
         logic [63:0] pr;
         pr = (64'(r_ff[s-1]) * 64'(adsr_pkg::root_c(s))) >> 30;
         r_ff[s]    <= fp_ff[s-1][32-s] ? pr[31:0] : r_ff[s-1];
         fp_ff[s]   <= fp_ff[s-1];
         ip_ff[s]   <= ip_ff[s-1];
         zero_ff[s] <= zero_ff[s-1];
         side_ff[s] <= side_ff[s-1];
      end
   end

   // blend stage 1: y and scale factor
   logic        v1_ff;
   logic [31:0] y_ff;
   logic [15:0] lvl_ff;
   adsr_pkg::seg_type seg1_ff;
   logic [15:0] lvl_sat;
   assign lvl_sat = (side_ff[NS-1].lvl > adsr_pkg::LEVEL_ONE) ?
                    adsr_pkg::LEVEL_ONE : side_ff[NS-1].lvl;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v_ff[NS-1];
      y_ff    <= zero_ff[NS-1] ? 32'd0 : (r_ff[NS-1] >> ip_ff[NS-1]);
      lvl_ff  <= lvl_sat;
      seg1_ff <= side_ff[NS-1].seg;
   end

   // blend stage 2: multiply and round
   logic        v2_ff;
   logic [15:0] amp_ff;
   logic [2:0]  seg2_ff;
   logic [16:0] amp_n;
   logic [47:0] prod;
   always_comb begin
      prod  = '0;
      amp_n = '0;
      unique case (seg1_ff)
         adsr_pkg::SEG_ATTACK: amp_n = 17'((48'(y_ff) + 48'(1 << 14)) >> 15);
         adsr_pkg::SEG_DECAY: begin
            prod  = 48'(y_ff) * 48'(adsr_pkg::LEVEL_ONE - lvl_ff);
            amp_n = 17'((prod + (48'd1 << 29)) >> 30) + 17'(lvl_ff);
         end
         adsr_pkg::SEG_SUSTAIN: amp_n = 17'(lvl_ff);
         adsr_pkg::SEG_RELEASE: begin
            prod  = 48'(y_ff) * 48'(lvl_ff);
            amp_n = 17'((prod + (48'd1 << 29)) >> 30);
         end
         default: amp_n = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      amp_ff  <= (amp_n > 17'd32768) ? adsr_pkg::LEVEL_ONE : amp_n[15:0];
      seg2_ff <= seg1_ff;
   end
   assign out_valid = v2_ff;
   assign out_amp   = amp_ff;
   assign out_seg   = seg2_ff;
endmodule

>>> hw/rtl/adsr_envelope_curve_top.sv
// Top level of the ADSR envelope block: registers, divider, log and exp pipes.
// Depends on adsr_pkg, adsr_seg_div, adsr_log, adsr_exp.
//
//  channel | ports              | handshake
//  req     | req_time_tick      | start && !busy
//  rsp     | rsp_amplitude/seg  | done strobe, one cycle per result
//  csr     | csr_index/data     | csr_valid && csr_ready
//
// One item per cycle; the pipeline has FRAC_BITS+1 divider stages, 34 log stages
// and 33 exp/blend stages, set by the divide, squaring and root chains.
// busy is always low; results cannot be stalled.
// Reset clears all valid bits and loads the register defaults.
module adsr_envelope_curve_top #(
   parameter int TIME_WIDTH = adsr_pkg::TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = adsr_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_time_tick,
   output logic        done,
   output logic [15:0] rsp_amplitude,
   output logic [2:0]  rsp_segment,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic [3:0][31:0] len_ff;
   logic [15:0]      lvl_ff;
   logic [2:0][15:0] curve_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         lvl_ff   <= '0;
         curve_ff <= {3{16'd256}};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            adsr_pkg::REG_ATTACK_LEN:    len_ff[0]   <= csr_data;
            adsr_pkg::REG_DECAY_LEN:     len_ff[1]   <= csr_data;
            adsr_pkg::REG_SUSTAIN_LEN:   len_ff[2]   <= csr_data;
            adsr_pkg::REG_RELEASE_LEN:   len_ff[3]   <= csr_data;
            adsr_pkg::REG_SUSTAIN_LEVEL: lvl_ff      <= csr_data[15:0];
            adsr_pkg::REG_ATTACK_CURVE:  curve_ff[0] <= csr_data[15:0];
            adsr_pkg::REG_DECAY_CURVE:   curve_ff[1] <= csr_data[15:0];
            adsr_pkg::REG_RELEASE_CURVE: curve_ff[2] <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic               d_valid, l_valid;
   logic [FRAC_BITS:0] d_base;
   adsr_pkg::side_type d_side, l_side;
   logic [63:0]        l_p;
   logic [1:0]         l_kind;

   adsr_seg_div #(.TIME_WIDTH(TIME_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock, .reset, .in_valid(start && !busy), .in_time(req_time_tick),
      .seg_len(len_ff), .lvl(lvl_ff), .curves(curve_ff),
      .out_valid(d_valid), .out_base(d_base), .out_side(d_side));

   adsr_log #(.FRAC_BITS(FRAC_BITS)) u_log (
      .clock, .reset, .in_valid(d_valid), .in_base(d_base), .in_side(d_side),
      .out_valid(l_valid), .out_p(l_p), .out_kind(l_kind), .out_side(l_side));

   adsr_exp u_exp (
      .clock, .reset, .in_valid(l_valid), .in_p(l_p), .in_kind(l_kind),
      .in_side(l_side), .out_valid(done), .out_amp(rsp_amplitude),
      .out_seg(rsp_segment));

   a_amp_range: assert property (@(posedge clock) disable iff (reset)
      done |-> rsp_amplitude <= adsr_pkg::LEVEL_ONE) else $error("amplitude range");
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_segment == adsr_pkg::SEG_OUTSIDE) |-> rsp_amplitude == 16'd0)
      else $error("outside not zero");
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !done) else $error("result after reset");
endmodule
